[rtl/gp_port_fade_and_edge_unit_core_assert.svh]
// assertion macros for the gp port fade and edge unit
`ifndef GP_PORT_FADE_AND_EDGE_UNIT_CORE_ASSERT_SVH
`define GP_PORT_FADE_AND_EDGE_UNIT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define GPFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define GPFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GPFE_ASSERT(lbl, prop, msg)
`define GPFE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/gpfe_pkg.sv]
// shared types, constants and helpers of the gp port fade and edge unit
`default_nettype none

package gpfe_pkg;

  localparam int NUM_PORTS    = 3;
  localparam int EVENT_PERIOD = 10;
  localparam int PORTS_MAX    = 3;
  localparam int ACTIVE_PORTS = (NUM_PORTS < PORTS_MAX) ? NUM_PORTS : PORTS_MAX;
  localparam int RGB_PORT     = 2;

  localparam logic [7:0] POLL_LIMIT = 8'(EVENT_PERIOD);

  localparam int CONF_RISE_IRQ_BIT = 2;
  localparam int CONF_FALL_IRQ_BIT = 3;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef enum logic [1:0] {
    MODE_PWM = 2'd0,
    MODE_OUT = 2'd1,
    MODE_ADC = 2'd2,
    MODE_IN  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_CHECK = 2'd0,
    ST_ADC   = 2'd1,
    ST_RISE  = 2'd2,
    ST_FALL  = 2'd3
  } edge_e;

  typedef enum logic [2:0] {
    CFG_PORT1_CONF  = 3'd0,
    CFG_PORT2_CONF  = 3'd1,
    CFG_PORT3_CONF  = 3'd2,
    CFG_FADE_PERIOD = 3'd3,
    CFG_RGB_MODE    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic       func;
    logic [1:0] port_sel;
    logic [7:0] write_value;
    logic [2:0] pin_levels;
    logic [9:0] adc_sample1;
    logic [9:0] adc_sample2;
    logic [9:0] adc_sample3;
  } in_item_t;

  typedef struct packed {
    logic [7:0] duty1;
    logic [7:0] duty2;
    logic [7:0] duty3;
    logic [7:0] value1;
    logic [7:0] value2;
    logic [7:0] value3;
    logic [2:0] pin_drive;
    logic [2:0] fade_busy;
    logic [5:0] edge_events;
    logic       irq;
  } out_item_t;

  // configuration register file
  typedef struct packed {
    logic [PORTS_MAX-1:0][3:0] port_conf;
    logic [7:0]                fade_period;
    logic                      rgb_mode;
  } cfg_t;

  // one item as it is applied to the port state
  typedef struct packed {
    logic                      en;
    logic                      tick;
    logic                      host_wr;
    logic [1:0]                port_sel;
    logic [7:0]                write_value;
    logic [PORTS_MAX-1:0]      pin_levels;
    logic [PORTS_MAX-1:0][9:0] samples;
  } step_t;

  function automatic mode_e mode_of(cfg_t cfg, int p);
    return mode_e'(cfg.port_conf[p][1:0]);
  endfunction

  // rgb mode takes port 3 away from the input, adc and output logic
  function automatic logic gated(cfg_t cfg, int p);
    return (p == RGB_PORT) && cfg.rgb_mode;
  endfunction

endpackage

`default_nettype wire

[rtl/gpfe_fade.sv]
// pwm duty fading: per-port duty levels, busy flags and fade tick counter
`default_nettype none
`include "gp_port_fade_and_edge_unit_core_assert.svh"

module gpfe_fade import gpfe_pkg::*; (
  input  wire  logic                      clk_i,
  input  wire  logic                      rst_ni,
  input  wire  step_t                     step_i,
  input  wire  cfg_t                      cfg_i,
  input  wire  logic [PORTS_MAX-1:0][7:0] port_value_i,
  output logic       [PORTS_MAX-1:0][7:0] fade_level_d_o,
  output logic       [PORTS_MAX-1:0]      busy_d_o
);

  logic [PORTS_MAX-1:0][7:0] fade_level_q, fade_level_d;
  logic [PORTS_MAX-1:0]      busy_q, busy_d;
  logic [7:0]                fade_cnt_q, fade_cnt_d;
  logic                      cnt_hit;
  logic                      do_tick;

  assign do_tick = step_i.en && step_i.tick;
  assign cnt_hit = fade_cnt_q >= cfg_i.fade_period;

  always_comb begin
    logic [7:0] stepped;
    fade_level_d = fade_level_q;
    busy_d       = busy_q;
    fade_cnt_d   = fade_cnt_q;
    stepped      = '0;
    if (do_tick) begin
      for (int p = 0; p < PORTS_MAX; p++) begin
        if (p < ACTIVE_PORTS && mode_of(cfg_i, p) == MODE_PWM) begin
          if (cfg_i.fade_period == '0) begin
            fade_level_d[p] = port_value_i[p];
          end else if (cnt_hit && fade_level_q[p] != port_value_i[p]) begin
            stepped = (fade_level_q[p] < port_value_i[p]) ? fade_level_q[p] + 8'd1
                                                          : fade_level_q[p] - 8'd1;
            fade_level_d[p] = stepped;
            busy_d[p]       = (stepped != port_value_i[p]);
          end
        end
      end
      fade_cnt_d = cnt_hit ? '0 : fade_cnt_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_level_q <= '0;
      busy_q       <= '0;
      fade_cnt_q   <= '0;
    end else begin
      fade_level_q <= fade_level_d;
      busy_q       <= busy_d;
      fade_cnt_q   <= fade_cnt_d;
    end
  end

  assign fade_level_d_o = fade_level_d;
  assign busy_d_o       = busy_d;

  // with no fade period a pwm port follows its target on the very tick
  `GPFE_ASSERT(a_fade_jump, do_tick && cfg_i.fade_period == '0 && cfg_i.port_conf[0][1:0] == MODE_PWM |=> fade_level_q[0] == $past(port_value_i[0]), "pwm duty did not jump to target")

endmodule

`default_nettype wire

[rtl/gpfe_poll.sv]
// port value registers, output latch and per-port edge/adc state machines
`default_nettype none
`include "gp_port_fade_and_edge_unit_core_assert.svh"

module gpfe_poll import gpfe_pkg::*; (
  input  wire  logic                        clk_i,
  input  wire  logic                        rst_ni,
  input  wire  step_t                       step_i,
  input  wire  cfg_t                        cfg_i,
  output logic       [PORTS_MAX-1:0][7:0]   port_value_o,
  output logic       [PORTS_MAX-1:0][7:0]   port_value_d_o,
  output logic       [PORTS_MAX-1:0]        out_latch_d_o,
  output logic       [2*PORTS_MAX-1:0]      events_o,
  output logic                              irq_o
);

  logic  [PORTS_MAX-1:0][7:0] port_value_q, port_value_d;
  edge_e [PORTS_MAX-1:0]      edge_q, edge_d;
  logic  [PORTS_MAX-1:0]      latch_q, latch_d;
  logic  [7:0]                poll_cnt_q, poll_cnt_d;
  logic  [2*PORTS_MAX-1:0]    events;
  logic                       irq;

  always_comb begin
    port_value_d = port_value_q;
    edge_d       = edge_q;
    latch_d      = latch_q;
    poll_cnt_d   = poll_cnt_q;
    events       = '0;
    irq          = 1'b0;
    if (step_i.en && step_i.host_wr) begin
      for (int p = 0; p < PORTS_MAX; p++) begin
        if (p < ACTIVE_PORTS && step_i.port_sel == 2'(p)) begin
          port_value_d[p] = step_i.write_value;
          if (!gated(cfg_i, p) && mode_of(cfg_i, p) == MODE_OUT) begin
            // an output port keeps only 0 or 1
            if (step_i.write_value == '0) begin
              latch_d[p] = 1'b0;
            end else begin
              latch_d[p]      = 1'b1;
              port_value_d[p] = 8'd1;
            end
          end
        end
      end
    end else if (step_i.en && step_i.tick) begin
      if (poll_cnt_q > POLL_LIMIT) begin
        poll_cnt_d = '0;
        for (int p = 0; p < PORTS_MAX; p++) begin
          if (p < ACTIVE_PORTS && !gated(cfg_i, p)) begin
            case (edge_q[p])
              ST_CHECK: begin
                if (mode_of(cfg_i, p) == MODE_ADC) begin
                  edge_d[p] = ST_ADC;
                end else if (mode_of(cfg_i, p) == MODE_IN) begin
                  edge_d[p] = ST_RISE;
                end
              end
              ST_ADC: begin
                port_value_d[p] = step_i.samples[p][9:2];
              end
              ST_RISE: begin
                if (step_i.pin_levels[p]) begin
                  port_value_d[p] = 8'd1;
                  events[2*p]     = 1'b1;
                  if (cfg_i.port_conf[p][CONF_RISE_IRQ_BIT]) begin
                    irq = 1'b1;
                  end
                  edge_d[p] = ST_FALL;
                end
              end
              ST_FALL: begin
                if (!step_i.pin_levels[p]) begin
                  port_value_d[p] = 8'd0;
                  events[2*p+1]   = 1'b1;
                  if (cfg_i.port_conf[p][CONF_FALL_IRQ_BIT]) begin
                    irq = 1'b1;
                  end
                  edge_d[p] = ST_RISE;
                end
              end
              default: begin
                edge_d[p] = ST_CHECK;
              end
            endcase
          end
        end
      end else begin
        poll_cnt_d = poll_cnt_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_value_q <= '0;
      edge_q       <= {PORTS_MAX{ST_CHECK}};
      latch_q      <= '0;
      poll_cnt_q   <= '0;
    end else begin
      port_value_q <= port_value_d;
      edge_q       <= edge_d;
      latch_q      <= latch_d;
      poll_cnt_q   <= poll_cnt_d;
    end
  end

  assign port_value_o   = port_value_q;
  assign port_value_d_o = port_value_d;
  assign out_latch_d_o  = latch_d;
  assign events_o       = events;
  assign irq_o          = irq;

  // the poll counter wraps right after passing the event period
  `GPFE_ASSERT(a_poll_cnt_range, poll_cnt_q <= POLL_LIMIT + 8'd1, "poll counter out of range")

endmodule

`default_nettype wire

[rtl/gp_port_fade_and_edge_unit_core.sv]
// top level of the gp port fade and edge unit: item registers, config and result
//
// use of the block
// - input channel (in_valid_i / in_ready_o / in_item_i): each item is a tick
//   (func 0) or a host write of one port value register (func 1)
// - result channel (out_valid_o / out_ready_i / out_item_o): exactly one result
//   item per input item, in order: duties, value registers, pin drive, fade
//   busy flags, edge event pulses and irq as they stand after that item
// - config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
//   always ready, writes the port modes and irq enables, the fade period
//   and rgb mode; write it only while no item is in flight
// - path: an accepted item is held in the input register, the port update
//   runs between that register and the result register, and the result
//   is valid once the result register has taken it
// - throughput: one item per cycle while out_ready_i stays high; the input
//   register frees up in the same cycle it hands its item to the result
//   register
// - stall: while the receiver holds out_ready_i low the result stays put and
//   one more item is taken into the input register, then in_ready_o drops
// - reset: all port state, counters, configuration and both valid flags clear
`default_nettype none
`include "gp_port_fade_and_edge_unit_core_assert.svh"

module gp_port_fade_and_edge_unit_core import gpfe_pkg::*; (
  input  wire  logic      clk_i,
  input  wire  logic      rst_ni,
  input  wire  logic      in_valid_i,
  output logic            in_ready_o,
  input  wire  in_item_t  in_item_i,
  output logic            out_valid_o,
  input  wire  logic      out_ready_i,
  output out_item_t       out_item_o,
  input  wire  logic      cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire  logic [2:0] cfg_index_i,
  input  wire  logic [7:0] cfg_data_i
);

  // configuration registers
  cfg_t cfg_q, cfg_d;

  // input stage
  in_item_t in_q;
  logic     in_valid_q, in_valid_d;
  logic     in_take;
  logic     advance;

  // result stage
  out_item_t out_q, res;
  logic      out_valid_q, out_valid_d;

  step_t                     step;
  logic [PORTS_MAX-1:0][7:0] port_value;
  logic [PORTS_MAX-1:0][7:0] port_value_d;
  logic [PORTS_MAX-1:0][7:0] fade_level_d;
  logic [PORTS_MAX-1:0]      busy_d;
  logic [PORTS_MAX-1:0]      latch_d;
  logic [2*PORTS_MAX-1:0]    events;
  logic                      irq;
  logic [PORTS_MAX-1:0][7:0] duty;
  logic [PORTS_MAX-1:0]      drive;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PORT1_CONF:  cfg_d.port_conf[0] = cfg_data_i[3:0];
        CFG_PORT2_CONF:  cfg_d.port_conf[1] = cfg_data_i[3:0];
        CFG_PORT3_CONF:  cfg_d.port_conf[2] = cfg_data_i[3:0];
        CFG_FADE_PERIOD: cfg_d.fade_period  = cfg_data_i;
        CFG_RGB_MODE:    cfg_d.rgb_mode     = cfg_data_i[0];
        default: begin
          // indexes past the register list are dropped
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  // the item moves on when the result register is free or being emptied
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_take     = in_valid_i && in_ready_o;
  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_comb begin
    step             = '0;
    step.en          = advance;
    step.tick        = (in_q.func == FUNC_TICK);
    step.host_wr     = (in_q.func == FUNC_WRITE);
    step.port_sel    = in_q.port_sel;
    step.write_value = in_q.write_value;
    step.pin_levels  = in_q.pin_levels;
    step.samples[0]  = in_q.adc_sample1;
    step.samples[1]  = in_q.adc_sample2;
    step.samples[2]  = in_q.adc_sample3;
  end

  gpfe_poll u_poll (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .cfg_i          (cfg_q),
    .port_value_o   (port_value),
    .port_value_d_o (port_value_d),
    .out_latch_d_o  (latch_d),
    .events_o       (events),
    .irq_o          (irq)
  );

  // fading works from the targets as they stood before this tick's poll
  gpfe_fade u_fade (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .cfg_i          (cfg_q),
    .port_value_i   (port_value),
    .fade_level_d_o (fade_level_d),
    .busy_d_o       (busy_d)
  );

  // result as seen after this item: non-pwm ports show duty 0, pin drive
  // only for output ports that rgb mode leaves alone
  always_comb begin
    for (int p = 0; p < PORTS_MAX; p++) begin
      duty[p]  = (mode_of(cfg_q, p) == MODE_PWM) ? fade_level_d[p] : 8'd0;
      drive[p] = latch_d[p] && mode_of(cfg_q, p) == MODE_OUT && !gated(cfg_q, p);
    end
    res             = '0;
    res.duty1       = duty[0];
    res.duty2       = duty[1];
    res.duty3       = duty[2];
    res.value1      = port_value_d[0];
    res.value2      = port_value_d[1];
    res.value3      = port_value_d[2];
    res.pin_drive   = drive;
    res.fade_busy   = busy_d;
    res.edge_events = events;
    res.irq         = irq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // irq only comes with an edge event of the same item
  `GPFE_ASSERT(a_irq_has_event, out_valid_o && out_item_o.irq |-> out_item_o.edge_events != '0, "irq without edge event")
  // a port never drives its pin while it shows a pwm duty
  `GPFE_ASSERT(a_drive_not_pwm, out_valid_o && out_item_o.pin_drive[0] |-> out_item_o.duty1 == '0, "port 1 drives pin with pwm duty")
  // an empty result register never holds back the input side
  `GPFE_ASSERT(a_ready_when_empty, !out_valid_q |-> in_ready_o, "input stalled with empty result register")

endmodule

`default_nettype wire
